FILE: hw/rtl/four_port_router_arbiter_unit_macros.svh
// Assertion macros for the four-port router arbiter.
// Taken in by the RTL files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef FOUR_PORT_ROUTER_ARBITER_UNIT_MACROS_SVH
`define FOUR_PORT_ROUTER_ARBITER_UNIT_MACROS_SVH

// same-cycle implication
`define FPRA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FPRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/fpra_pkg.sv
// Shared types, codes and helpers of the four-port router arbiter.
// No dependencies; used by fpra_route_mem and four_port_router_arbiter_unit.
`default_nettype none

package fpra_pkg;

  localparam int NumPorts    = 4;
  localparam int PortW       = 2;
  localparam int PktW        = 48;
  localparam int AddrBitsDef = 8;
  localparam int DataBitsDef = 32;
  localparam int RouteAddrW  = 8;
  localparam int InDataW     = 208;
  localparam int OutDataW    = 56;
  localparam int ApbAddrW    = 3;
  localparam int ApbDataW    = 32;

  localparam logic [PortW-1:0] LastServedRst = 2'd3;
  localparam logic [3:0]       PortEnableRst = 4'hF;

  localparam logic RegPortEnable = 1'b0;
  localparam logic RegArbMode    = 1'b1;

  typedef enum logic {
    OpTick    = 1'b0,
    OpRouteWr = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StFwd     = 2'd0,
    StNoRoute = 2'd1,
    StOutOff  = 2'd2
  } status_e;

  typedef struct packed {
    logic             present;
    logic [PortW-1:0] port;
  } route_ent_t;

  typedef struct packed {
    logic             valid;
    logic [PortW-1:0] port;
  } grant_t;

  typedef struct packed {
    logic [PktW-1:0]  packet;
    logic [PortW-1:0] out_port;
    status_e          status;
    logic [PortW-1:0] granted;
  } result_t;

  // first eligible port scanning upward from start, wrapping
  function automatic grant_t arb_pick(input logic [NumPorts-1:0] elig,
                                      input logic [PortW-1:0] start);
    grant_t           g;
    logic [PortW-1:0] p;
    g = '0;
    for (int i = NumPorts - 1; i >= 0; i--) begin
      p = start + PortW'(i);
      if (elig[p]) begin
        g.valid = 1'b1;
        g.port  = p;
      end
    end
    return g;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fpra_route_mem.sv
// Routing table memory: one write port, one registered read port, clear sweep after reset.
// Depends on fpra_pkg.
`default_nettype none

module fpra_route_mem import fpra_pkg::*; #(
  parameter int ADDR_BITS = AddrBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 wr_en_i,
  input  wire logic [ADDR_BITS-1:0] wr_addr_i,
  input  wire route_ent_t           wr_data_i,
  input  wire logic                 rd_en_i,
  input  wire logic [ADDR_BITS-1:0] rd_addr_i,
  output route_ent_t                rd_data_o,
  output logic                      busy_o
);

  localparam int Depth = 1 << ADDR_BITS;

  route_ent_t mem_q [Depth];
  route_ent_t rd_data_q;

  logic                 clr_busy_q, clr_busy_d;
  logic [ADDR_BITS-1:0] clr_cnt_q, clr_cnt_d;

  logic                 we;
  logic [ADDR_BITS-1:0] waddr;
  route_ent_t           wdata;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (&clr_cnt_q) begin
        clr_busy_d = 1'b0;
      end
    end
    we    = clr_busy_q || wr_en_i;
    waddr = clr_busy_q ? clr_cnt_q : wr_addr_i;
    wdata = clr_busy_q ? route_ent_t'('0) : wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_busy_q;

endmodule

`default_nettype wire

FILE: hw/rtl/four_port_router_arbiter_unit.sv
// Four-port router arbiter: top level with arbitration, pipeline and register port.
// Depends on fpra_pkg, fpra_route_mem and four_port_router_arbiter_unit_macros.svh.
//
// Input stream (s_axis): one word per item. tuser carries the opcode: a tick
// picks one enabled, requesting port (fixed priority from north, or round robin
// after the last served port) and looks up its destination; a route write
// stores one routing table entry and gives no output. A tick with no eligible
// port gives no output either.
// Output stream (m_axis): one word per granted tick with the granted port,
// status (forwarded, no route, output disabled), looked-up port and packet.
// Throughput: one item per cycle while s_axis_tready is high; the table clear and
// a stalled output hold it low. Arbitration and the table read happen in the
// accept cycle; status is resolved from the registered read data when stage one
// moves into the output register.
// Reset: a sweep clears the routing table, one entry per cycle; s_axis_tready
// stays low until it ends. APB writes are taken during the sweep.
// Stall: the output register plus one stage behind it hold two results. While a
// result waits, route writes and ticks without a grant keep flowing; the next
// granted tick fills the stage and then s_axis_tready drops.
`default_nettype none
`include "four_port_router_arbiter_unit_macros.svh"

module four_port_router_arbiter_unit import fpra_pkg::*; #(
  parameter int ADDR_BITS = AddrBitsDef,
  parameter int DATA_BITS = DataBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // s_axis_tdata: request_mask[3:0], packet_north[51:4], packet_south[99:52],
  //   packet_east[147:100], packet_west[195:148], route_address[203:196],
  //   route_port[205:204], zero pad[207:206]
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // s_axis_tuser: opcode[0]
  input  wire logic [0:0]          s_axis_tuser,
  // m_axis_tdata: granted_port[1:0], status[3:2], out_port[5:4],
  //   packet_out[53:6], zero pad[55:54]
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0]      prdata,
  output logic                     pready
);

  // config registers
  logic [NumPorts-1:0] port_enable_q;
  logic                arb_mode_q;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_enable_q <= PortEnableRst;
      arb_mode_q    <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        RegPortEnable: port_enable_q <= pwdata[NumPorts-1:0];
        RegArbMode:    arb_mode_q    <= pwdata[0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegPortEnable: prdata = {{(ApbDataW-NumPorts){1'b0}}, port_enable_q};
      RegArbMode:    prdata = {{(ApbDataW-1){1'b0}}, arb_mode_q};
      default:       prdata = '0;
    endcase
  end

  // input unpack
  op_e                   in_op;
  logic [NumPorts-1:0]   in_req;
  logic [PktW-1:0]       in_pkt [NumPorts];
  logic [RouteAddrW-1:0] in_raddr;
  logic [PortW-1:0]      in_rport;

  assign in_op    = op_e'(s_axis_tuser[0]);
  assign in_req   = s_axis_tdata[NumPorts-1:0];
  assign in_raddr = s_axis_tdata[NumPorts + NumPorts*PktW +: RouteAddrW];
  assign in_rport = s_axis_tdata[NumPorts + NumPorts*PktW + RouteAddrW +: PortW];

  for (genvar p = 0; p < NumPorts; p++) begin : g_pkt
    assign in_pkt[p] = s_axis_tdata[NumPorts + p*PktW +: PktW];
  end

  // pipeline state
  logic             s1_valid_q, s1_valid_d;
  logic [PortW-1:0] s1_port_q;
  logic [PktW-1:0]  s1_pkt_q;
  logic             out_valid_q, out_valid_d;
  result_t          out_q, out_d;
  logic [PortW-1:0] last_q;

  logic             mem_busy;
  route_ent_t       rd_ent;
  logic             s_accept, tick_grant, route_wr, out_ready, s1_move;
  logic [PortW-1:0] start;
  grant_t           grant;
  logic [PktW-1:0]  grant_pkt;
  logic [ADDR_BITS-1:0] rd_addr, wr_addr;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s1_move       = s1_valid_q && out_ready;
  assign s_axis_tready = !mem_busy && (!s1_valid_q || out_ready);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign start      = arb_mode_q ? last_q + 1'b1 : '0;
  assign grant      = arb_pick(in_req & port_enable_q, start);
  assign grant_pkt  = in_pkt[grant.port];
  assign tick_grant = s_accept && (in_op == OpTick) && grant.valid;
  assign route_wr   = s_accept && (in_op == OpRouteWr);
  assign rd_addr    = grant_pkt[DATA_BITS +: ADDR_BITS];
  assign wr_addr    = ADDR_BITS'(in_raddr);

  fpra_route_mem #(
    .ADDR_BITS(ADDR_BITS)
  ) u_route_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (route_wr),
    .wr_addr_i(wr_addr),
    .wr_data_i('{present: 1'b1, port: in_rport}),
    .rd_en_i  (tick_grant),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_ent),
    .busy_o   (mem_busy)
  );

  always_comb begin
    s1_valid_d = tick_grant ? 1'b1 : (s1_move ? 1'b0 : s1_valid_q);
    out_valid_d = s1_move ? 1'b1 : ((out_valid_q && m_axis_tready) ? 1'b0 : out_valid_q);

    out_d.granted = s1_port_q;
    out_d.packet  = s1_pkt_q;
    if (!rd_ent.present) begin
      out_d.status   = StNoRoute;
      out_d.out_port = '0;
    end else begin
      out_d.out_port = rd_ent.port;
      out_d.status   = port_enable_q[rd_ent.port] ? StFwd : StOutOff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_q      <= LastServedRst;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (tick_grant) begin
        last_q <= grant.port;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_grant) begin
      s1_port_q <= grant.port;
      s1_pkt_q  <= grant_pkt;
    end
    if (s1_move) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-PktW-3*PortW){1'b0}}, out_q.packet, out_q.out_port,
                          out_q.status, out_q.granted};

  `FPRA_ASSERT_NOW(a_no_accept_clear, mem_busy, !s_axis_tready, "word accepted during table clear")
  `FPRA_ASSERT_NEXT(a_last_served, tick_grant, last_q == $past(grant.port), "last served not updated")
  `FPRA_ASSERT_NOW(a_no_route_port, out_valid_q && out_q.status == StNoRoute, out_q.out_port == '0, "no-route result with nonzero port")
  `FPRA_ASSERT_NEXT(a_s1_hold, s1_valid_q && !out_ready, s1_valid_q && $stable(s1_pkt_q), "stage one lost under stall")

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Testbench for four_port_router_arbiter_unit: route writes and arbitration ticks,
// directed first, then random, checked word by word against an in-bench model.
// Depends on fpra_pkg and the block's RTL.
module tb import fpra_pkg::*; ();

  localparam logic [ApbAddrW-1:0] AddrPortEnable = ApbAddrW'(4 * RegPortEnable);
  localparam logic [ApbAddrW-1:0] AddrArbMode    = ApbAddrW'(4 * RegArbMode);
  localparam int TableDepth = 1 << AddrBitsDef;

  typedef logic [PktW-1:0] pkt_t;

  typedef struct packed {
    op_e                  op;
    logic [PortW-1:0]     rport;
    logic [RouteAddrW-1:0] raddr;
    logic [3:0][PktW-1:0] pkts;
    logic [NumPorts-1:0]  req;
  } word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [0:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  four_port_router_arbiter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // router model
  logic [PortW-1:0]    route_port_m [TableDepth];
  bit                  route_valid_m [TableDepth];
  logic [PortW-1:0]    last_grant_m;
  logic [NumPorts-1:0] enable_m;
  bit                  round_robin_m;

  result_t             grant_q [$];
  int                  mismatches = 0;
  bit                  quiet = 1'b0;
  logic [7:0]          dst_pool [16];
  result_t             got_r;
  result_t             want_r;

  initial forever #2 clk_i = ~clk_i;

  always @(negedge clk_i) m_axis_tready <= quiet || ($urandom_range(99) >= 16);

  function automatic void predict_grant(input word_t w);
    logic [PortW-1:0]      start;
    logic [PortW-1:0]      p;
    logic [AddrBitsDef-1:0] dst;
    result_t               r;
    bit                    hit;
    hit = 1'b0;
    if (w.op == OpRouteWr) begin
      route_port_m[w.raddr[AddrBitsDef-1:0]]  = w.rport;
      route_valid_m[w.raddr[AddrBitsDef-1:0]] = 1'b1;
      return;
    end
    start = round_robin_m ? last_grant_m + 2'd1 : 2'd0;
    for (int i = 0; i < NumPorts; i++) begin
      p = start + i[PortW-1:0];
      if (!hit && enable_m[p] && w.req[p]) begin
        hit = 1'b1;
        dst = w.pkts[p][DataBitsDef +: AddrBitsDef];
        r.granted = p;
        r.packet  = w.pkts[p];
        if (!route_valid_m[dst]) begin
          r.status   = StNoRoute;
          r.out_port = '0;
        end else begin
          r.out_port = route_port_m[dst];
          r.status   = enable_m[r.out_port] ? StFwd : StOutOff;
        end
        last_grant_m = p;
        grant_q.push_back(r);
      end
    end
  endfunction

  function automatic pkt_t mk_pkt(input logic [7:0] src, input logic [7:0] dst,
                                  input logic [31:0] data);
    return {src, dst, data};
  endfunction

  function automatic logic [7:0] pick_dst();
    if ($urandom_range(99) < 75) return dst_pool[$urandom_range(15)];
    return 8'($urandom_range(255));
  endfunction

  function automatic pkt_t rand_pkt();
    return mk_pkt(8'($urandom_range(255)), pick_dst(), $urandom());
  endfunction

  function automatic word_t tick_word(input logic [3:0] req, input pkt_t pn, input pkt_t ps,
                                     input pkt_t pe, input pkt_t pw);
    word_t w;
    w      = '0;
    w.op   = OpTick;
    w.req  = req;
    w.pkts = {pw, pe, ps, pn};
    // route fields carry noise on ticks
    w.raddr = 8'($urandom_range(255));
    w.rport = 2'($urandom_range(3));
    return w;
  endfunction

  function automatic word_t route_word(input logic [7:0] addr, input logic [1:0] port);
    word_t w;
    w       = '0;
    w.op    = OpRouteWr;
    w.raddr = addr;
    w.rport = port;
    w.req   = 4'($urandom_range(15));
    w.pkts  = {rand_pkt(), rand_pkt(), rand_pkt(), rand_pkt()};
    return w;
  endfunction

  task automatic send_word(input word_t w);
    while (!quiet && $urandom_range(99) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= w.op;
    s_axis_tdata  <= {2'b00, w.rport, w.raddr, w.pkts, w.req};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_grant(w);
    @(negedge clk_i);
  endtask

  task automatic settle(input int extra);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (grant_q.size() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic reg_write(input logic [ApbAddrW-1:0] addr, input logic [3:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= ($urandom() & ~32'hF) | {28'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == AddrPortEnable) enable_m = val;
    else round_robin_m = val[0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input logic [3:0] en, input bit rr);
    settle(6);
    reg_write(AddrPortEnable, en);
    reg_write(AddrArbMode, {3'b000, rr});
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_r = m_axis_tdata[PktW+3*PortW-1:0];
      if (grant_q.size() == 0) begin
        note_mismatch("unexpected word", '0, 64'(m_axis_tdata));
      end else begin
        want_r = grant_q.pop_front();
        if (got_r.granted !== want_r.granted)
          note_mismatch("granted_port", 64'(want_r.granted), 64'(got_r.granted));
        if (got_r.status !== want_r.status)
          note_mismatch("status", 64'(want_r.status), 64'(got_r.status));
        if (got_r.out_port !== want_r.out_port)
          note_mismatch("out_port", 64'(want_r.out_port), 64'(got_r.out_port));
        if (got_r.packet !== want_r.packet)
          note_mismatch("packet_out", 64'(want_r.packet), 64'(got_r.packet));
      end
    end
  end

  task automatic test_no_route();
    send_word(tick_word(4'hF, '1, '1, '1, '1));
    send_word(tick_word(4'h0, '1, '1, '1, '1));
    send_word(tick_word(4'h8, '1, '1, '1, '0));
  endtask

  task automatic test_forward();
    send_word(route_word(8'hFF, 2'd3));
    send_word(route_word(8'h00, 2'd1));
    send_word(route_word(8'hA5, 2'd2));
    send_word(tick_word(4'h2, '0, '1, '0, '0));
    send_word(tick_word(4'h1, '0, '1, '1, '1));
    send_word(tick_word(4'h4, '0, '0, mk_pkt(8'h5A, 8'hA5, 32'hDEAD_BEEF), '0));
  endtask

  task automatic test_fixed_priority();
    send_word(tick_word(4'hF, rand_pkt(), rand_pkt(), rand_pkt(), rand_pkt()));
    send_word(tick_word(4'hE, rand_pkt(), rand_pkt(), rand_pkt(), rand_pkt()));
    send_word(tick_word(4'hC, rand_pkt(), rand_pkt(), rand_pkt(), rand_pkt()));
    send_word(tick_word(4'hF, rand_pkt(), rand_pkt(), rand_pkt(), rand_pkt()));
  endtask

  task automatic test_round_robin();
    configure(4'hF, 1'b1);
    repeat (5) send_word(tick_word(4'hF, rand_pkt(), rand_pkt(), rand_pkt(), rand_pkt()));
    send_word(tick_word(4'h9, rand_pkt(), rand_pkt(), rand_pkt(), rand_pkt()));
  endtask

  task automatic test_port_disable();
    configure(4'h5, 1'b0);
    send_word(route_word(8'h10, 2'd1));
    send_word(tick_word(4'hF, mk_pkt(8'h01, 8'h10, 32'h1234_5678), rand_pkt(), rand_pkt(),
                        rand_pkt()));
    send_word(tick_word(4'hA, rand_pkt(), rand_pkt(), rand_pkt(), rand_pkt()));
    configure(4'h0, 1'b1);
    send_word(tick_word(4'hF, rand_pkt(), rand_pkt(), rand_pkt(), rand_pkt()));
    configure(4'hF, 1'b0);
  endtask

  task automatic test_random();
    logic [3:0] en;
    bit         rr;
    int         cnt;
    logic [3:0] req;
    for (int ph = 0; ph < 8; ph++) begin
      cnt = 170;
      en  = 4'($urandom_range(15));
      rr  = ph[0];
      case (ph)
        0, 1: en = 4'hF;
        4: begin
          en  = 4'h0;
          cnt = 30;
        end
        5: en = 4'h1;
        6: en = 4'h8;
        default: ;
      endcase
      configure(en, rr);
      quiet = (ph == 1);
      for (int n = 0; n < cnt; n++) begin
        if (ph == 2 && n == cnt / 2) settle(0);
        if ($urandom_range(99) < 15) begin
          send_word(route_word(pick_dst(), 2'($urandom_range(3))));
        end else begin
          req = ($urandom_range(3) == 0) ? 4'hF : 4'($urandom_range(15));
          send_word(tick_word(req, rand_pkt(), rand_pkt(), rand_pkt(), rand_pkt()));
        end
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    for (int i = 0; i < TableDepth; i++) begin
      route_port_m[i]  = '0;
      route_valid_m[i] = 1'b0;
    end
    last_grant_m  = LastServedRst;
    enable_m      = PortEnableRst;
    round_robin_m = 1'b0;
    dst_pool[0]   = 8'h00;
    dst_pool[1]   = 8'hFF;
    for (int i = 2; i < 16; i++) dst_pool[i] = 8'($urandom_range(255));
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_no_route();
    test_forward();
    test_fixed_priority();
    test_round_robin();
    test_port_disable();
    test_random();
    settle(8);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/fpra_pkg.sv
hw/rtl/fpra_route_mem.sv
hw/rtl/four_port_router_arbiter_unit.sv
dv/tb.sv
